// File: design/nlp_pkg.sv
// Package for the numeric literal parser: payload structs, base codes,
// character decode info and default width. No dependencies.
package nlp_pkg;

    localparam int NLP_VALUE_W       = 64;   // width of the value field on the port
    localparam int NLP_VALUE_W_DEF   = 64;   // default accumulator width

    typedef logic [NLP_VALUE_W-1:0] t_value;

    typedef enum logic [1:0] {
        BASE_DEC = 2'd0,
        BASE_HEX = 2'd1,
        BASE_OCT = 2'd2,
        BASE_BIN = 2'd3
    } t_base;

    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
    localparam logic [7:0] CH_LF    = 8'h66;  // 'f'
    localparam logic [7:0] CH_UA    = 8'h41;  // 'A'
    localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
    localparam logic [7:0] CH_LX    = 8'h78;  // 'x'
    localparam logic [7:0] CH_LO    = 8'h6F;  // 'o'
    localparam logic [7:0] CH_LB    = 8'h62;  // 'b'

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        t_value      value;
        logic        ok;
        logic [1:0]  base_code;
    } t_out_item;

    // decoded view of one character
    typedef struct packed {
        logic        is_digit;   // 0-9, a-f or A-F
        logic [3:0]  digit;      // its value when is_digit
        logic        is_zero;    // exactly '0'
        logic        is_prefix;  // x, o or b (lower case only)
        t_base       pfx_base;   // base the prefix letter selects
    } t_char_info;

endpackage

// File: design/nlp_char_class.sv
// Character decoder: ASCII byte to digit value and prefix flags.
// Depends on nlp_pkg.
module nlp_char_class import nlp_pkg::*; (
    input  logic [7:0] i_char,
    output t_char_info o_info
);

    logic [7:0] w_off;

    always_comb begin
        o_info   = '0;
        w_off    = 8'd0;
        if (i_char >= CH_ZERO && i_char <= CH_NINE) begin
            w_off = i_char - CH_ZERO;
            o_info.is_digit = 1'b1;
        end else if (i_char >= CH_LA && i_char <= CH_LF) begin
            w_off = i_char - CH_LA + 8'd10;
            o_info.is_digit = 1'b1;
        end else if (i_char >= CH_UA && i_char <= CH_UF) begin
            w_off = i_char - CH_UA + 8'd10;
            o_info.is_digit = 1'b1;
        end
        o_info.digit   = w_off[3:0];
        o_info.is_zero = (i_char == CH_ZERO);
        o_info.is_prefix = (i_char == CH_LX) || (i_char == CH_LO) || (i_char == CH_LB);
        if (i_char == CH_LX) begin
            o_info.pfx_base = BASE_HEX;
        end else if (i_char == CH_LO) begin
            o_info.pfx_base = BASE_OCT;
        end else begin
            o_info.pfx_base = BASE_BIN;
        end
    end

endmodule

// File: design/nlp_step.sv
// Per-character step: token state, shift-add accumulate with overflow check,
// and the result of a finished token. Depends on nlp_pkg.
module nlp_step import nlp_pkg::*; #(
    parameter int VALUE_WIDTH = NLP_VALUE_W_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,      // a character is consumed this cycle
    input  t_char_info i_info,
    input  logic       i_last,
    output t_out_item  o_result     // meaningful when i_fire && i_last
);

    localparam int SW = VALUE_WIDTH + 4;

    typedef enum logic [1:0] {
        PH_FIRST    = 2'd0,
        PH_ZERO     = 2'd1,
        PH_PREFIXED = 2'd2,
        PH_DIGITS   = 2'd3
    } t_phase;

    t_phase                 r_phase, n_phase;
    t_base                  r_base,  n_base;
    logic [VALUE_WIDTH-1:0] r_acc,   n_acc;
    logic                   r_has_digit, n_has_digit;
    logic                   r_bad,   n_bad;

    logic                   w_take;
    logic                   w_fits;
    logic [SW-1:0]          w_ext;
    logic [SW-1:0]          w_sum;
    logic                   w_ok;

    always_comb begin
        w_take = 1'b0;
        w_fits = 1'b0;
        w_ext  = '0;
        w_sum  = '0;
        n_phase     = r_phase;
        n_base      = r_base;
        n_acc       = r_acc;
        n_has_digit = r_has_digit;
        n_bad       = r_bad;

        // a new token starts from a clean slate
        if (r_phase == PH_FIRST) begin
            n_base      = BASE_DEC;
            n_acc       = '0;
            n_has_digit = 1'b0;
            n_bad       = 1'b0;
        end

        unique case (r_phase)
            PH_FIRST: begin
                if (i_info.is_zero) begin
                    n_has_digit = 1'b1;
                    n_phase     = PH_ZERO;
                end else begin
                    n_phase = PH_DIGITS;
                    w_take  = 1'b1;
                end
            end
            PH_ZERO: begin
                if (i_info.is_prefix) begin
                    n_base      = i_info.pfx_base;
                    n_has_digit = 1'b0;
                    n_acc       = '0;
                    n_phase     = PH_PREFIXED;
                end else begin
                    n_phase = PH_DIGITS;
                    w_take  = 1'b1;
                end
            end
            PH_PREFIXED, PH_DIGITS: begin
                w_take = 1'b1;
            end
        endcase

        // digit legal for the base in use
        unique case (n_base)
            BASE_DEC: w_fits = i_info.is_digit && (i_info.digit < 4'd10);
            BASE_HEX: w_fits = i_info.is_digit;
            BASE_OCT: w_fits = i_info.is_digit && (i_info.digit < 4'd8);
            BASE_BIN: w_fits = i_info.is_digit && (i_info.digit < 4'd2);
        endcase

        // acc * radix + digit, four guard bits catch overflow
        w_ext = SW'(n_acc);
        unique case (n_base)
            BASE_DEC: w_sum = (w_ext << 3) + (w_ext << 1);
            BASE_HEX: w_sum = w_ext << 4;
            BASE_OCT: w_sum = w_ext << 3;
            BASE_BIN: w_sum = w_ext << 1;
        endcase
        w_sum = w_sum + SW'(i_info.digit);

        if (w_take) begin
            if (!w_fits) begin
                n_bad = 1'b1;
            end else begin
                n_has_digit = 1'b1;
                if (!n_bad) begin
                    if (|w_sum[SW-1:VALUE_WIDTH]) begin
                        n_bad = 1'b1;
                    end else begin
                        n_acc = w_sum[VALUE_WIDTH-1:0];
                    end
                end
            end
        end

        w_ok = n_has_digit && !n_bad;
        o_result.value     = w_ok ? t_value'(n_acc) : '0;
        o_result.ok        = w_ok;
        o_result.base_code = n_base;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_base      <= BASE_DEC;
            r_acc       <= '0;
            r_has_digit <= 1'b0;
            r_bad       <= 1'b0;
        end else if (i_fire) begin
            if (i_last) begin
                r_phase     <= PH_FIRST;
                r_base      <= BASE_DEC;
                r_acc       <= '0;
                r_has_digit <= 1'b0;
                r_bad       <= 1'b0;
            end else begin
                r_phase     <= n_phase;
                r_base      <= n_base;
                r_acc       <= n_acc;
                r_has_digit <= n_has_digit;
                r_bad       <= n_bad;
            end
        end
    end

endmodule

// File: design/numeric_literal_parser_top.sv
// Top level of the numeric literal parser: input register, step logic and
// result register. Depends on nlp_pkg, nlp_char_class and nlp_step.
//
//  channel | direction | payload     | transfer when
//  --------+-----------+-------------+-------------------------
//  in      | sink      | t_in_item   | i_in_valid && o_in_ready
//  out     | source    | t_out_item  | o_out_valid && i_out_ready
//
// One character per cycle while no token end waits on a stalled result. A
// character is held in the input register, is folded into the token state
// by one shift-add and compare, and on the last character the result lands
// in the output register, from which it is presented on the out channel.
// Synchronous active-low reset empties both registers and starts a new token.
// A stalled result only holds up a character that ends a token; other
// characters keep flowing while the result waits.
module numeric_literal_parser_top import nlp_pkg::*; #(
    parameter int VALUE_WIDTH = NLP_VALUE_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    t_char_info w_info;
    t_out_item  w_result;
    logic       w_fire;

    // consume the held character unless it ends a token and the
    // result register is still occupied
    assign w_fire = r_in_valid &&
                    (!r_in_item.last_char || !r_out_valid || i_out_ready);

    assign o_in_ready  = !r_in_valid || w_fire;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    nlp_char_class u_class (
        .i_char (r_in_item.char_code),
        .o_info (w_info)
    );

    nlp_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_info   (w_info),
        .i_last   (r_in_item.last_char),
        .o_result (w_result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_in_item.last_char) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_item.last_char) begin
            r_out_item <= w_result;
        end
    end

endmodule

// File: design/nlp_checker.sv
// Port-level checks for the numeric literal parser, bound to the top level.
// Depends on nlp_pkg and numeric_literal_parser_top.
module nlp_checker import nlp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    // a waiting character holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input changed while stalled");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // a failed token reports zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.ok |-> o_out_item.value == '0)
        else $error("nonzero value on failed token");

    // with no pending result the input side never stalls
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind numeric_literal_parser_top nlp_checker u_nlp_checker (.*);
